>>> design/affi_pkg.sv
`timescale 1ns / 1ps

package affi_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PW        = 2 * WORD_BITS;   // product / magnitude width
    localparam int QW        = WORD_BITS + 1;   // quotient bits, one per divide stage
    localparam int NLANE     = 6;
    localparam int CFG_AW    = 3;

    typedef logic signed [WORD_BITS-1:0] t_word;

    typedef enum logic [CFG_AW-1:0] {
        REG_ZERO_LIMIT = 3'd0,
        REG_FB_M00     = 3'd1,
        REG_FB_M10     = 3'd2,
        REG_FB_M01     = 3'd3,
        REG_FB_M11     = 3'd4,
        REG_FB_SHIFT_X = 3'd5,
        REG_FB_SHIFT_Y = 3'd6
    } t_reg_idx;

    // one divide lane: partial remainder, dividend bits still to shift in
    // (top end) with quotient bits collecting at the bottom end
    typedef struct packed {
        logic          ovf;
        logic          neg;
        logic [PW-1:0] rem;
        logic [QW-1:0] xq;
    } t_lane;

    typedef struct packed {
        logic                  singular;
        logic [PW-1:0]         dmag;
        t_lane [NLANE-1:0]     lane;
    } t_pipe;

    typedef struct packed {
        logic                  saturated;
        logic                  singular;
        t_word [NLANE-1:0]     val;
    } t_res;

endpackage

>>> design/affi_front.sv
`timescale 1ns / 1ps

module affi_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  affi_pkg::t_word                  i_m00,
    input  affi_pkg::t_word                  i_m10,
    input  affi_pkg::t_word                  i_m01,
    input  affi_pkg::t_word                  i_m11,
    input  affi_pkg::t_word                  i_shift_x,
    input  affi_pkg::t_word                  i_shift_y,
    input  logic [affi_pkg::WORD_BITS-2:0]   i_zero_lim,
    output logic                             o_valid,
    output affi_pkg::t_pipe                  o_pipe
);
    import affi_pkg::*;

    function automatic logic [PW-1:0] mag_scaled(input t_word a);
        logic [WORD_BITS-1:0] m;
        m = a[WORD_BITS-1] ? (~a + 1'b1) : a;
        return PW'(m) << FRAC_BITS;
    endfunction

    function automatic logic [PW-1:0] abs_wide(input logic signed [PW:0] x);
        logic [PW:0] y;
        y = x[PW] ? (~x + 1'b1) : x;
        return y[PW-1:0];
    endfunction

    // stage 1: input capture
    logic  r_v1;
    t_word r_a00, r_a10, r_a01, r_a11, r_tx, r_ty;
    // stage 2: products
    logic                 r_v2;
    logic signed [PW-1:0] r_pa, r_pb, r_pc, r_pd, r_pe, r_pf;
    logic [PW-1:0]        r_bmag2 [4];
    logic                 r_bsn2  [4];
    // stage 3: differences
    logic                 r_v3;
    logic signed [PW:0]   r_det, r_t4, r_t5;
    logic [PW-1:0]        r_bmag3 [4];
    logic                 r_bsn3  [4];
    // stage 4: magnitudes
    logic                 r_v4;
    logic [PW-1:0]        r_dmag;
    logic                 r_dneg;
    logic [PW-1:0]        r_n4  [NLANE];
    logic                 r_sn4 [NLANE];
    // stage 5: divider setup
    logic                 r_v5;
    t_pipe                r_pipe;
    t_pipe                n_pipe;

    logic [PW-1:0] w_lim_sh;
    logic [PW-1:0] w_hi  [NLANE];
    logic [PW-1:0] w_nsh [NLANE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a00 <= i_m00;
            r_a10 <= i_m10;
            r_a01 <= i_m01;
            r_a11 <= i_m11;
            r_tx  <= i_shift_x;
            r_ty  <= i_shift_y;

            r_pa <= PW'(r_a00) * PW'(r_a11);
            r_pb <= PW'(r_a01) * PW'(r_a10);
            r_pc <= PW'(r_a01) * PW'(r_ty);
            r_pd <= PW'(r_a11) * PW'(r_tx);
            r_pe <= PW'(r_a10) * PW'(r_tx);
            r_pf <= PW'(r_a00) * PW'(r_ty);
            // basis numerators: m11, -m10, -m01, m00
            r_bmag2[0] <= mag_scaled(r_a11);
            r_bsn2[0]  <= r_a11[WORD_BITS-1];
            r_bmag2[1] <= mag_scaled(r_a10);
            r_bsn2[1]  <= !r_a10[WORD_BITS-1] && (r_a10 != '0);
            r_bmag2[2] <= mag_scaled(r_a01);
            r_bsn2[2]  <= !r_a01[WORD_BITS-1] && (r_a01 != '0);
            r_bmag2[3] <= mag_scaled(r_a00);
            r_bsn2[3]  <= r_a00[WORD_BITS-1];

            r_det   <= (PW+1)'(r_pa) - (PW+1)'(r_pb);
            r_t4    <= (PW+1)'(r_pc) - (PW+1)'(r_pd);
            r_t5    <= (PW+1)'(r_pe) - (PW+1)'(r_pf);
            r_bmag3 <= r_bmag2;
            r_bsn3  <= r_bsn2;

            r_dneg <= r_det[PW];
            r_dmag <= abs_wide(r_det);
            for (int i = 0; i < 4; i++) begin
                r_n4[i]  <= r_bmag3[i];
                r_sn4[i] <= r_bsn3[i];
            end
            r_n4[4]  <= abs_wide(r_t4);
            r_sn4[4] <= r_t4[PW];
            r_n4[5]  <= abs_wide(r_t5);
            r_sn4[5] <= r_t5[PW];

            r_pipe <= n_pipe;
        end
    end

    // quotient is taken of 2*n*2^F / d; dividend bits above the quotient window
    // seed the remainder, and if they already reach d the result overflows
    always_comb begin
        w_lim_sh        = PW'(i_zero_lim) << FRAC_BITS;
        n_pipe.singular = (r_dmag == '0) || (r_dmag < w_lim_sh);
        n_pipe.dmag     = r_dmag;
        for (int i = 0; i < NLANE; i++) begin
            w_hi[i]             = r_n4[i] >> (WORD_BITS - FRAC_BITS);
            w_nsh[i]            = r_n4[i] << (FRAC_BITS + 1);
            n_pipe.lane[i].ovf  = w_hi[i] >= r_dmag;
            n_pipe.lane[i].neg  = r_sn4[i] ^ r_dneg;
            n_pipe.lane[i].rem  = n_pipe.lane[i].ovf ? '0 : w_hi[i];
            n_pipe.lane[i].xq   = w_nsh[i][QW-1:0];
        end
    end

    assign o_valid = r_v5;
    assign o_pipe  = r_pipe;

endmodule

>>> design/affi_div_step.sv
`timescale 1ns / 1ps

module affi_div_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  affi_pkg::t_pipe i_pipe,
    output logic            o_valid,
    output affi_pkg::t_pipe o_pipe
);
    import affi_pkg::*;

    logic          r_valid;
    t_pipe         r_pipe;
    t_pipe         n_pipe;
    logic [PW:0]   w_r2   [NLANE];
    logic [PW:0]   w_diff [NLANE];
    logic          w_ge   [NLANE];

    // one restoring step per lane, all lanes share the divisor
    always_comb begin
        n_pipe = i_pipe;
        for (int i = 0; i < NLANE; i++) begin
            w_r2[i]   = {i_pipe.lane[i].rem, i_pipe.lane[i].xq[QW-1]};
            w_diff[i] = w_r2[i] - {1'b0, i_pipe.dmag};
            w_ge[i]   = w_r2[i] >= {1'b0, i_pipe.dmag};
            n_pipe.lane[i].rem = w_ge[i] ? w_diff[i][PW-1:0] : w_r2[i][PW-1:0];
            n_pipe.lane[i].xq  = {i_pipe.lane[i].xq[QW-2:0], w_ge[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_valid = r_valid;
    assign o_pipe  = r_pipe;

endmodule

>>> design/affi_round.sv
`timescale 1ns / 1ps

module affi_round (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  affi_pkg::t_pipe             i_pipe,
    output logic                        o_valid,
    output logic                        o_singular,
    output logic                        o_saturated,
    output affi_pkg::t_word [affi_pkg::NLANE-1:0] o_val
);
    import affi_pkg::*;

    logic          r_valid;
    logic          r_singular;
    logic [QW-1:0] r_qr  [NLANE];
    logic          r_neg [NLANE];
    logic          r_ovf [NLANE];

    logic [QW:0]   w_sum  [NLANE];
    logic [QW-1:0] w_lim  [NLANE];
    logic [QW-1:0] w_q    [NLANE];
    logic [QW-1:0] w_sgn  [NLANE];
    logic          w_sat  [NLANE];
    logic [QW-1:0] w_lim_pos;

    // half-up rounding from the extra quotient bit
    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            w_sum[i] = {1'b0, i_pipe.lane[i].xq} + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_singular <= i_pipe.singular;
            for (int i = 0; i < NLANE; i++) begin
                r_qr[i]  <= w_sum[i][QW:1];
                r_neg[i] <= i_pipe.lane[i].neg;
                r_ovf[i] <= i_pipe.lane[i].ovf;
            end
        end
    end

    always_comb begin
        w_lim_pos   = QW'(1) << (WORD_BITS - 1);
        o_saturated = 1'b0;
        for (int i = 0; i < NLANE; i++) begin
            w_lim[i]    = r_neg[i] ? w_lim_pos : w_lim_pos - 1'b1;
            w_sat[i]    = r_ovf[i] || (r_qr[i] > w_lim[i]);
            w_q[i]      = w_sat[i] ? w_lim[i] : r_qr[i];
            w_sgn[i]    = r_neg[i] ? (~w_q[i] + 1'b1) : w_q[i];
            o_val[i]    = w_sgn[i][WORD_BITS-1:0];
            o_saturated = o_saturated | w_sat[i];
        end
    end

    assign o_valid    = r_valid;
    assign o_singular = r_singular;

endmodule

>>> design/affine_inverse_2d.sv
`timescale 1ns / 1ps

// Inverse of a 2D affine transform (basis and translation, signed Q16.16).
// One transform is accepted per clock while the output buffer has room; each
// result passes through 5 stages of multiply/determinant/setup, 33 stages
// of a restoring divider that resolves one quotient bit per stage in six
// parallel lanes, one rounding stage and the output register. A two-entry
// output buffer lets the pipe keep taking requests while a result waits.
// Results whose |det| is zero or below the zero limit return the fallback
// transform with the singular flag; clamped values set the saturated flag.
// Configuration registers must only be written while the block is idle.

module affine_inverse_2d (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            s_axis_tvalid,
    output logic                                            s_axis_tready,
    // m00, m10, m01, m11, shift_x, shift_y (32 bits each, from bit 0 up)
    input  logic [affi_pkg::NLANE*affi_pkg::WORD_BITS-1:0]  s_axis_tdata,
    output logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready,
    // inv_m00, inv_m10, inv_m01, inv_m11, inv_shift_x, inv_shift_y
    output logic [affi_pkg::NLANE*affi_pkg::WORD_BITS-1:0]  m_axis_tdata,
    // singular, saturated
    output logic [1:0]                                      m_axis_tuser,
    input  logic                                            i_cfg_we,
    input  logic [affi_pkg::CFG_AW-1:0]                     i_cfg_addr,
    input  logic [affi_pkg::WORD_BITS-1:0]                  i_cfg_wdata
);
    import affi_pkg::*;

    logic [WORD_BITS-2:0] r_zero_lim;
    t_word                r_fb [NLANE];

    logic   w_en;
    logic   w_front_v;
    t_pipe  w_pipe  [QW+1];
    logic   w_valid [QW+1];
    logic   w_rnd_v;
    logic   w_rnd_sing;
    logic   w_rnd_sat;
    t_word [NLANE-1:0] w_rnd_val;
    t_res   n_res;

    logic   r_ov, r_sv;
    t_res   r_head, r_skid;
    logic   w_push, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_lim <= (WORD_BITS-1)'(1);
            r_fb[0]    <= t_word'(1) <<< FRAC_BITS;
            r_fb[1]    <= '0;
            r_fb[2]    <= '0;
            r_fb[3]    <= t_word'(1) <<< FRAC_BITS;
            r_fb[4]    <= '0;
            r_fb[5]    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_ZERO_LIMIT: r_zero_lim <= i_cfg_wdata[WORD_BITS-2:0];
                REG_FB_M00:     r_fb[0]    <= i_cfg_wdata;
                REG_FB_M10:     r_fb[1]    <= i_cfg_wdata;
                REG_FB_M01:     r_fb[2]    <= i_cfg_wdata;
                REG_FB_M11:     r_fb[3]    <= i_cfg_wdata;
                REG_FB_SHIFT_X: r_fb[4]    <= i_cfg_wdata;
                REG_FB_SHIFT_Y: r_fb[5]    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // whole pipe moves unless the output buffer is full
    assign w_en          = !r_sv;
    assign s_axis_tready = w_en;

    affi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (s_axis_tvalid),
        .i_m00      (s_axis_tdata[0*WORD_BITS +: WORD_BITS]),
        .i_m10      (s_axis_tdata[1*WORD_BITS +: WORD_BITS]),
        .i_m01      (s_axis_tdata[2*WORD_BITS +: WORD_BITS]),
        .i_m11      (s_axis_tdata[3*WORD_BITS +: WORD_BITS]),
        .i_shift_x  (s_axis_tdata[4*WORD_BITS +: WORD_BITS]),
        .i_shift_y  (s_axis_tdata[5*WORD_BITS +: WORD_BITS]),
        .i_zero_lim (r_zero_lim),
        .o_valid    (w_front_v),
        .o_pipe     (w_pipe[0])
    );

    assign w_valid[0] = w_front_v;

    for (genvar k = 0; k < QW; k++) begin : g_div
        affi_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_pipe  (w_pipe[k]),
            .o_valid (w_valid[k+1]),
            .o_pipe  (w_pipe[k+1])
        );
    end

    affi_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_valid[QW]),
        .i_pipe      (w_pipe[QW]),
        .o_valid     (w_rnd_v),
        .o_singular  (w_rnd_sing),
        .o_saturated (w_rnd_sat),
        .o_val       (w_rnd_val)
    );

    always_comb begin
        n_res.singular  = w_rnd_sing;
        n_res.saturated = w_rnd_sing ? 1'b0 : w_rnd_sat;
        for (int i = 0; i < NLANE; i++) begin
            n_res.val[i] = w_rnd_sing ? r_fb[i] : w_rnd_val[i];
        end
    end

    assign w_push = w_en && w_rnd_v;
    assign w_pop  = r_ov && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || w_pop) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= w_push;
            end
        end else if (w_push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || w_pop) begin
            r_head <= r_sv ? r_skid : n_res;
        end
        if (r_ov && !w_pop && w_push) begin
            r_skid <= n_res;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_head.val;
    assign m_axis_tuser  = {r_head.saturated, r_head.singular};

endmodule

>>> design/affi_chk.sv
`timescale 1ns / 1ps

module affi_chk (
    input logic                                            i_clk,
    input logic                                            i_rst_n,
    input logic                                            s_axis_tvalid,
    input logic                                            s_axis_tready,
    input logic                                            m_axis_tvalid,
    input logic                                            m_axis_tready,
    input logic [affi_pkg::NLANE*affi_pkg::WORD_BITS-1:0]  m_axis_tdata,
    input logic [1:0]                                      m_axis_tuser,
    input logic                                            i_cfg_we
);
    import affi_pkg::*;

    // requests in flight
    logic [7:0] r_cnt;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 8'(w_in_acc) - 8'(w_out_acc);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("singular result flagged saturated");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> r_cnt != 8'd0)
        else $error("result without a request");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 8'd41)
        else $error("more requests in flight than pipeline holds");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> r_cnt == 8'd0)
        else $error("register write with requests in flight");

endmodule

bind affine_inverse_2d affi_chk u_affi_chk (.*);

>>> test/affine_inverse_2d_tb.sv
`timescale 1ns / 1ps

module affine_inverse_2d_tb;
    import affi_pkg::*;

    localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

    // fields: m00, m10, m01, m11, shift_x, shift_y
    typedef logic [NLANE-1:0][WORD_BITS-1:0] xform_t;

    typedef struct packed {
        logic   saturated;
        logic   singular;
        xform_t val;
    } inverse_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    // m00, m10, m01, m11, shift_x, shift_y
    logic [NLANE*WORD_BITS-1:0] s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // inv_m00, inv_m10, inv_m01, inv_m11, inv_shift_x, inv_shift_y
    logic [NLANE*WORD_BITS-1:0] m_axis_tdata;
    // singular, saturated
    logic [1:0]                 m_axis_tuser;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]          i_cfg_addr = '0;
    logic [WORD_BITS-1:0]       i_cfg_wdata = '0;

    affine_inverse_2d i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    xform_t   pending_xforms[$];
    inverse_t expected_inverses[$];
    xform_t   fallback;
    logic [30:0] zero_limit;
    int       errors = 0;
    bit       calm = 1'b0;
    bit       rx_hold = 1'b0;
    int       phase_no = 0;

    function automatic logic [WORD_BITS-1:0] scaled_quot(input logic signed [65:0] num,
            input logic den_neg, input logic [127:0] dmag, inout logic sat);
        logic         neg;
        logic [65:0]  mag;
        logic [127:0] n, q, r, lim;
        neg = (num < 0) != den_neg;
        mag = (num < 0) ? -num : num;
        n = {62'b0, mag} << FRAC_BITS;
        q = n / dmag;
        r = n % dmag;
        if (r >= dmag - r)
            q = q + 1;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
            sat = 1'b1;
            q = lim;
        end
        return neg ? -q[WORD_BITS-1:0] : q[WORD_BITS-1:0];
    endfunction

    function automatic inverse_t invert_xform(input xform_t x);
        logic signed [65:0] a00, a10, a01, a11, tx, ty, det;
        logic [127:0]       dmag;
        logic               dneg, sat;
        inverse_t           res;
        a00 = $signed(x[0]); a10 = $signed(x[1]);
        a01 = $signed(x[2]); a11 = $signed(x[3]);
        tx  = $signed(x[4]); ty  = $signed(x[5]);
        det = a00 * a11 - a01 * a10;
        dneg = det < 0;
        dmag = {62'b0, (dneg ? -det : det)};
        sat = 1'b0;
        res = '0;
        if (dmag == 0 || dmag < ({97'b0, zero_limit} << FRAC_BITS)) begin
            res.val = fallback;
            res.singular = 1'b1;
            return res;
        end
        res.val[0] = scaled_quot(a11 <<< FRAC_BITS, dneg, dmag, sat);
        res.val[1] = scaled_quot(-(a10 <<< FRAC_BITS), dneg, dmag, sat);
        res.val[2] = scaled_quot(-(a01 <<< FRAC_BITS), dneg, dmag, sat);
        res.val[3] = scaled_quot(a00 <<< FRAC_BITS, dneg, dmag, sat);
        res.val[4] = scaled_quot(a01 * ty - a11 * tx, dneg, dmag, sat);
        res.val[5] = scaled_quot(a10 * tx - a00 * ty, dneg, dmag, sat);
        res.saturated = sat;
        return res;
    endfunction

    // sender
    xform_t tx_cur;
    int     tx_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_inverses.push_back(invert_xform(tx_cur));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_xforms.size() > 0) begin
                    tx_cur = pending_xforms.pop_front();
                    s_axis_tdata <= tx_cur;
                    s_axis_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0)
                        tx_gap = $urandom_range(1, 13);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    int       rx_gap = 0;
    inverse_t want, got;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser[1], m_axis_tuser[0], m_axis_tdata};
            if (expected_inverses.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
            end else begin
                want = expected_inverses.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected sat=%b sing=%b %h, got sat=%b sing=%b %h",
                                 want.saturated, want.singular, want.val,
                                 got.saturated, got.singular, got.val);
                end
            end
        end
        if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && !rx_hold;
        end
    end

    // long receiver hold-off so the pipe and output buffer back up
    initial begin
        while (phase_no != 1)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [WORD_BITS-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v;
        if (idx == REG_ZERO_LIMIT)
            zero_limit = v[30:0];
        else if (idx != REG_UNUSED)
            fallback[idx - 1] = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_xforms.size() != 0 || s_axis_tvalid || expected_inverses.size() != 0)
            @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    function automatic logic [WORD_BITS-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: case ($urandom_range(0, 6))
                   0: return 32'h8000_0000;
                   1: return 32'h7fff_ffff;
                   2: return 32'h0;
                   3: return 32'h1;
                   4: return 32'hffff_ffff;
                   5: return 32'h0001_0000;
                   default: return 32'hffff_0000;
               endcase
            1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_random(input int n);
        xform_t x;
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < NLANE; k++)
                x[k] = rand_word();
            if ($urandom_range(0, 7) == 0) begin
                // repeated rows: determinant exactly zero
                x[1] = x[0];
                x[3] = x[2];
            end
            pending_xforms.push_back(x);
        end
    endtask

    task automatic push_xform(input logic [WORD_BITS-1:0] a, b, c, d, e, f);
        pending_xforms.push_back({f, e, d, c, b, a});
    endtask

    initial begin
        zero_limit = 31'd1;
        fallback = '0;
        fallback[0] = 32'h0001_0000;
        fallback[3] = 32'h0001_0000;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, zero det, extremes, tiny det, negative det
        push_xform(32'h10000, 0, 0, 32'h10000, 0, 0);
        push_xform(0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000);
        push_xform(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 5, 6);
        push_xform(32'h8000_0000, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        push_xform(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                   32'h8000_0000, 32'h7fff_ffff);
        push_xform(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                   32'h8000_0000, 32'h8000_0000);
        push_xform(1, 0, 0, 1, 32'h7fff_ffff, 32'h8000_0000);
        push_xform(32'h100, 0, 0, 32'h100, 0, 0);   // |det| right at the limit
        push_xform(32'hff, 0, 0, 32'h100, 0, 0);    // just below it
        push_xform(0, 32'h10000, 32'h10000, 0, 32'h30000, 32'hfffe_0000);
        push_xform(32'h20000, 32'h8000, 32'hffff_8000, 32'h30000, 32'h12345, 32'hfff0_0000);
        push_xform(32'hffff_ffff, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 1);
        push_xform(32'h30000, 0, 0, 32'h30000, 32'h10000, 32'h10000);  // rounding of 1/3
        push_xform(32'hfffd_0000, 32'h1, 32'h1, 32'h30000, 32'h1, 32'hffff_ffff);
        push_random(10);
        drain();

        phase_no = 1;
        write_reg(REG_ZERO_LIMIT, 32'h0);
        write_reg(REG_FB_M00, $urandom);
        write_reg(REG_FB_M10, $urandom);
        write_reg(REG_FB_M01, $urandom);
        write_reg(REG_FB_M11, $urandom);
        write_reg(REG_FB_SHIFT_X, $urandom);
        write_reg(REG_FB_SHIFT_Y, $urandom);
        write_reg(REG_UNUSED, $urandom);
        push_random(250);
        drain();

        phase_no = 2;
        write_reg(REG_ZERO_LIMIT, 32'h7fff_ffff);
        write_reg(REG_FB_M00, 32'h8000_0000);
        write_reg(REG_FB_M10, 32'h7fff_ffff);
        write_reg(REG_FB_M01, 32'hffff_ffff);
        write_reg(REG_FB_M11, 32'h0);
        write_reg(REG_FB_SHIFT_X, 32'h7fff_ffff);
        write_reg(REG_FB_SHIFT_Y, 32'h8000_0000);
        push_random(100);
        drain();

        phase_no = 3;
        write_reg(REG_ZERO_LIMIT, $urandom_range(0, 32'h2_0000));
        write_reg(REG_FB_M00, $urandom);
        write_reg(REG_FB_SHIFT_Y, $urandom);
        push_random(300);
        drain();

        phase_no = 4;
        calm = 1'b1;
        write_reg(REG_ZERO_LIMIT, $urandom_range(1, 32'h40));
        push_random(120);
        drain();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
design/affi_pkg.sv
design/affi_front.sv
design/affi_div_step.sv
design/affi_round.sv
design/affine_inverse_2d.sv
design/affi_chk.sv
test/affine_inverse_2d_tb.sv
